@@ hdl/sieve_prime_counter_macros.svh @@
// Assertion helpers for the checker of this block.
`ifndef SIEVE_PRIME_COUNTER_MACROS_SVH
`define SIEVE_PRIME_COUNTER_MACROS_SVH

// Checked at every rising edge outside reset.
`define SPC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sieve_prime_counter: check failed");

// Checked at every rising edge, reset included.
`define SPC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sieve_prime_counter: check failed");

`endif

@@ hdl/spc_pkg.sv @@
package spc_pkg;

    localparam int MAX_ENTRIES    = 65536;
    localparam int ADDR_W         = $clog2(MAX_ENTRIES);
    localparam int LIMIT_W        = 16;
    localparam int COUNT_W        = 13;
    localparam int SMALLEST_PRIME = 2;
    localparam int MAX_COUNT      = 6542;

    typedef logic [LIMIT_W-1:0] t_limit;
    typedef logic [COUNT_W-1:0] t_count;

    // largest limit the map can hold
    localparam t_limit MAX_LIMIT = t_limit'(MAX_ENTRIES - 1);

endpackage

@@ hdl/spc_in_if.sv @@
interface spc_in_if;
    import spc_pkg::*;

    logic   valid;
    logic   ready;
    t_limit upper_limit;

    modport source (output valid, output upper_limit, input ready);
    modport sink   (input valid, input upper_limit, output ready);

endinterface

@@ hdl/spc_out_if.sv @@
interface spc_out_if;
    import spc_pkg::*;

    logic   valid;
    logic   ready;
    t_count prime_count;

    modport source (output valid, output prime_count, input ready);
    modport sink   (input valid, input prime_count, output ready);

endinterface

@@ hdl/sieve_prime_counter.sv @@
// Sieve prime counter: counts the primes in 2..n for one limit n per request.
// Channels: i_item (sink) carries upper_limit; o_result (source) carries
// prime_count. Both use valid/ready; a transaction completes at a rising edge
// with valid and ready high.
// The block handles one request at a time: i_item.ready is high only while
// the sequencer is idle. A limit below two goes straight to the finish state
// and gives 0. Otherwise the work runs through the bitmap, which has one
// write port and one registered read port, in these steps:
//   clear 0..n            : write 0 to each entry
//   walk i = 2..n         : read, check, root step, advance for each i
//   strike multiples      : mark each multiple from 2p up to n, for each prime p with p*p <= n
// and then hand the count over.
// Address, square and index adds share one 17-bit adder under the sequencer;
// the prime tally has its own incrementer.
// The result sits in an output register; the block takes a new transaction
// while it waits, and holds the next result in the finish state until the
// receiver takes the old one. A stalled result keeps its value.
// Reset (i_rst_n low at a rising edge) returns the sequencer to idle and drops
// o_result.valid; the bitmap needs no reset, each request clears it first.
module sieve_prime_counter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spc_in_if.sink    i_item,
    spc_out_if.source o_result
);
    import spc_pkg::*;

    localparam int SUM_W = LIMIT_W + 1;

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;   // wipe map entries 0..n
    localparam logic [2:0] S_READ  = 3'd2;   // fetch map[i]
    localparam logic [2:0] S_CHECK = 3'd3;   // count, maybe start striking
    localparam logic [2:0] S_MARK  = 3'd4;   // strike 2i, 3i, ... <= n
    localparam logic [2:0] S_ROOT  = 3'd5;   // track (i+1)^2 against n
    localparam logic [2:0] S_STEP  = 3'd6;   // i <= i + 1
    localparam logic [2:0] S_DONE  = 3'd7;   // hand result to output reg

    logic [2:0]       r_state, n_state;
    t_limit           r_n,     n_n;          // saturated limit
    t_limit           r_i,     n_i;          // walk index
    logic [SUM_W-1:0] r_k,     n_k;          // clear / strike address
    logic [SUM_W-1:0] r_sq,    n_sq;         // i*i while it is <= n
    logic             r_below, n_below;      // i*i <= n
    t_count           r_count, n_count;
    logic             r_out_valid, n_out_valid;
    t_count           r_out_data,  n_out_data;

    // composite bitmap
    logic             r_map [MAX_ENTRIES];
    logic             r_rd;
    logic             w_we;
    logic             w_wdata;
    logic [SUM_W-1:0] w_waddr;

    // shared adder
    logic [SUM_W-1:0] w_add_a, w_add_b, w_sum;

    t_limit           w_lim;

    assign i_item.ready         = (r_state == S_IDLE);
    assign o_result.valid       = r_out_valid;
    assign o_result.prime_count = r_out_data;

    assign w_lim = (i_item.upper_limit > MAX_LIMIT) ? MAX_LIMIT : i_item.upper_limit;
    assign w_sum = w_add_a + w_add_b;

    always_comb begin
        case (r_state)
            S_CLEAR: begin
                w_add_a = r_k;
                w_add_b = SUM_W'(1);
            end
            S_CHECK: begin
                w_add_a = {1'b0, r_i};
                w_add_b = {1'b0, r_i};
            end
            S_MARK: begin
                w_add_a = r_k;
                w_add_b = {1'b0, r_i};
            end
            S_ROOT: begin
                w_add_a = r_sq;
                w_add_b = {r_i, 1'b1};   // (i+1)^2 = i^2 + 2i + 1
            end
            S_STEP: begin
                w_add_a = {1'b0, r_i};
                w_add_b = SUM_W'(1);
            end
            default: begin
                w_add_a = '0;
                w_add_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_i         = r_i;
        n_k         = r_k;
        n_sq        = r_sq;
        n_below     = r_below;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_data  = r_out_data;
        w_we        = 1'b0;
        w_wdata     = 1'b0;
        w_waddr     = r_k;

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_n     = w_lim;
                    n_k     = '0;
                    n_count = '0;
                    if (w_lim < t_limit'(SMALLEST_PRIME)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = 1'b0;
                if (r_k[LIMIT_W-1:0] == r_n) begin
                    n_i     = t_limit'(SMALLEST_PRIME);
                    n_sq    = SUM_W'(SMALLEST_PRIME * SMALLEST_PRIME);
                    n_below = (SUM_W'(SMALLEST_PRIME * SMALLEST_PRIME) <= {1'b0, r_n});
                    n_state = S_READ;
                end else begin
                    n_k = w_sum;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_ROOT;
                if (!r_rd) begin
                    n_count = r_count + t_count'(1);
                    if (r_below) begin
                        n_k     = w_sum;        // first multiple 2i
                        n_state = S_MARK;
                    end
                end
            end
            S_MARK: begin
                if (r_k <= {1'b0, r_n}) begin
                    w_we    = 1'b1;
                    w_wdata = 1'b1;
                    n_k     = w_sum;
                end else begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (r_i == r_n) begin
                    n_state = S_DONE;
                end else begin
                    if (r_below) begin
                        n_sq    = w_sum;
                        n_below = (w_sum <= {1'b0, r_n});
                    end
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                n_i     = w_sum[LIMIT_W-1:0];
                n_state = S_READ;
            end
            S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_count;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_n        <= n_n;
        r_i        <= n_i;
        r_k        <= n_k;
        r_sq       <= n_sq;
        r_below    <= n_below;
        r_count    <= n_count;
        r_out_data <= n_out_data;
    end

    // bitmap: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_map[w_waddr[ADDR_W-1:0]] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_map[r_i[ADDR_W-1:0]];
    end

endmodule

@@ hdl/spc_checker.sv @@
`include "sieve_prime_counter_macros.svh"

module spc_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input spc_pkg::t_count      i_prime_count
);
    import spc_pkg::*;

    // one request at a time: busy straight after a transaction
    `SPC_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready)

    // no 16-bit limit has more primes than this
    `SPC_ASSERT(a_count_range, i_clk, i_rst_n, i_out_valid |-> (i_prime_count <= t_count'(MAX_COUNT)))

    // stalled result holds
    `SPC_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_prime_count)))

    // nothing offered straight out of reset
    `SPC_ASSERT_ALWAYS(a_reset_quiet, i_clk, (!$past(i_rst_n)) |-> !i_out_valid)

endmodule

bind sieve_prime_counter spc_checker u_spc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_prime_count (o_result.prime_count)
);
